@@ rtl/las_pkg.sv @@
// shared types and constants for the local alignment score fill block
package las_pkg;

    localparam int QUERY_MAX_DEF = 1024;
    localparam int SYM_W         = 8;
    localparam int SCORE_W       = 15;
    localparam int ROW_W         = 16;
    localparam int COL_W         = 11;
    localparam int CFG_W         = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int OUT_DATA_W    = 48;
    localparam logic [SCORE_W-1:0] SCORE_SAT = {SCORE_W{1'b1}};
    localparam logic [ROW_W-1:0]   ROW_SAT   = {ROW_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_QUERY   = 2'd1,
        KIND_SUBJECT = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_MATCH    = 2'd0,
        REG_MISMATCH = 2'd1,
        REG_GAP      = 2'd2,
        REG_NONE     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_DRAIN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic row_start;
        logic issue;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic qlen_zero;
        logic issue_done;
        logic last_flag;
        logic out_valid;
    } status_t;

endpackage

@@ rtl/las_ctrl.sv @@
// controller state machine sequencing rows over the query columns
module las_ctrl
    import las_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic [1:0] s_kind,
    input  logic    m_tready,
    input  status_t stat,
    output logic    s_tready,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   take;

    assign take = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && s_kind == KIND_SUBJECT)
                begin
                    state_next = stat.qlen_zero ? ST_FIN : ST_ROW;
                end
            end
            ST_ROW:
            begin
                if (stat.issue_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_FIN;
            ST_FIN:
            begin
                if (!stat.last_flag || !stat.out_valid || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.clear     = take && s_kind == KIND_START;
                cmd.append    = take && s_kind == KIND_QUERY;
                cmd.row_start = take && s_kind == KIND_SUBJECT;
            end
            ST_ROW:   cmd.issue = 1'b1;
            ST_DRAIN: cmd.issue = 1'b0;
            ST_FIN:
            begin
                cmd.finish   = 1'b1;
                cmd.load_out = stat.last_flag && (!stat.out_valid || m_tready);
            end
            default: cmd = '0;
        endcase
    end

endmodule

@@ rtl/las_datapath.sv @@
// query and row memories, cell scoring, best cell tracking and result register
module las_datapath
    import las_pkg::*;
#(
    parameter int QUERY_MAX = QUERY_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [SYM_W-1:0]      s_symbol,
    input  logic                  s_last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  m_tready,
    output status_t               stat,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(QUERY_MAX);
    localparam int LW = $clog2(QUERY_MAX + 1);
    localparam logic [LW-1:0] QMAX = LW'(QUERY_MAX);

    logic [SYM_W-1:0]   qmem [QUERY_MAX];
    logic [SCORE_W-1:0] pmem [QUERY_MAX];
    logic [SYM_W-1:0]   q_rd_reg;
    logic [SCORE_W-1:0] p_rd_reg;

    logic [CFG_W-1:0]   match_reg, mism_reg, gap_reg;
    logic [LW-1:0]      qlen_reg, pvlen_reg, col_reg, pcol_reg;
    logic               pvld_reg, last_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [SCORE_W-1:0] diag_reg, left_reg, top_reg;
    logic [ROW_W-1:0]   trow_reg;
    logic [LW-1:0]      tcol_reg;
    logic               ov_reg;
    logic [SCORE_W-1:0] os_reg;
    logic [ROW_W-1:0]   orow_reg;
    logic [COL_W-1:0]   ocol_reg;

    logic [SCORE_W-1:0] up, h;
    logic signed [17:0] d_t, u_t, l_t, m1, m2;

    always_ff @(posedge clk)
    begin
        if (cmd.append && qlen_reg < QMAX)
        begin
            qmem[qlen_reg[AW-1:0]] <= s_symbol;
        end
        if (pvld_reg)
        begin
            pmem[pcol_reg[AW-1:0]] <= h;
        end
        q_rd_reg <= qmem[col_reg[AW-1:0]];
        p_rd_reg <= pmem[col_reg[AW-1:0]];
    end

    // entries at or beyond pvlen were not written since start and read as zero
    assign up  = (pcol_reg < pvlen_reg) ? p_rd_reg : '0;
    assign d_t = (q_rd_reg == sym_reg)
               ? 18'(signed'({1'b0, diag_reg})) + 18'(signed'({1'b0, match_reg}))
               : 18'(signed'({1'b0, diag_reg})) - 18'(signed'({1'b0, mism_reg}));
    assign u_t = 18'(signed'({1'b0, up}))       - 18'(signed'({1'b0, gap_reg}));
    assign l_t = 18'(signed'({1'b0, left_reg})) - 18'(signed'({1'b0, gap_reg}));
    assign m1  = (d_t > u_t) ? d_t : u_t;
    assign m2  = (m1 > l_t) ? m1 : l_t;

    always_comb
    begin
        if (m2 < 0)
        begin
            h = '0;
        end
        else if (m2 > 18'(signed'({1'b0, SCORE_SAT})))
        begin
            h = SCORE_SAT;
        end
        else
        begin
            h = m2[SCORE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= CFG_W'(3);
            mism_reg  <= CFG_W'(3);
            gap_reg   <= CFG_W'(2);
            qlen_reg  <= '0;
            pvlen_reg <= '0;
            col_reg   <= '0;
            pcol_reg  <= '0;
            pvld_reg  <= 1'b0;
            last_reg  <= 1'b0;
            sym_reg   <= '0;
            row_reg   <= '0;
            diag_reg  <= '0;
            left_reg  <= '0;
            top_reg   <= '0;
            trow_reg  <= '0;
            tcol_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_MATCH:    match_reg <= cfg_data;
                    REG_MISMATCH: mism_reg  <= cfg_data;
                    REG_GAP:      gap_reg   <= cfg_data;
                    default:      match_reg <= match_reg;
                endcase
            end
            if (cmd.clear)
            begin
                qlen_reg  <= '0;
                pvlen_reg <= '0;
                row_reg   <= '0;
                top_reg   <= '0;
                trow_reg  <= '0;
                tcol_reg  <= '0;
            end
            if (cmd.append && qlen_reg < QMAX)
            begin
                qlen_reg <= qlen_reg + 1'b1;
            end
            if (cmd.row_start)
            begin
                sym_reg  <= s_symbol;
                last_reg <= s_last;
                col_reg  <= '0;
                diag_reg <= '0;
                left_reg <= '0;
                if (row_reg != ROW_SAT)
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            pvld_reg <= cmd.issue;
            pcol_reg <= col_reg;
            if (cmd.issue)
            begin
                col_reg <= col_reg + 1'b1;
            end
            if (pvld_reg)
            begin
                diag_reg <= up;
                left_reg <= h;
                if (h > top_reg)
                begin
                    top_reg  <= h;
                    trow_reg <= row_reg;
                    tcol_reg <= pcol_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                pvlen_reg <= qlen_reg;
            end
            if (cmd.load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            os_reg   <= top_reg;
            orow_reg <= trow_reg;
            ocol_reg <= COL_W'(tcol_reg);
        end
    end

    assign stat.qlen_zero  = (qlen_reg == '0);
    assign stat.issue_done = (col_reg == qlen_reg - 1'b1);
    assign stat.last_flag  = last_reg;
    assign stat.out_valid  = ov_reg;
    assign m_tvalid        = ov_reg;
    assign m_tdata         = {6'b0, ocol_reg, orow_reg, os_reg};

endmodule

@@ rtl/local_alignment_score_fill.sv @@
// top level of the local alignment score fill block
// Smith-Waterman local alignment scoring with a linear gap cost.
// Input stream: tuser carries the kind (start, query symbol, subject symbol),
// tdata the symbol byte, tlast marks the final subject symbol.
// A start transfer clears the alignment; query transfers append to the query
// memory (extra symbols beyond QUERY_MAX are dropped).
// Each subject transfer scores one matrix row, one query column per cycle:
// a subject symbol passes through an accept step, one issue step per column,
// a step that scores the last column and a finish step; with an empty query
// it goes straight from the accept step to the finish step.
// The subject transfer with tlast set produces one result transfer:
// best score, its 1-based row and column, or all zero when no cell scored.
// The result sits in an output register; a stalled receiver only holds up
// the block when a further result is ready before the previous one left.
// Reset restores the default scores and clears the query length and the
// best cell; no memory clearing pass is needed, the row memory reads as zero
// beyond the columns written since the last start.
module local_alignment_score_fill
    import las_pkg::*;
#(
    parameter int QUERY_MAX = QUERY_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SYM_W-1:0]      s_tdata,   // symbol
    input  logic [1:0]            s_tuser,   // kind
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // best_score, best_row, best_col, zero pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cmd_t    cmd;
    status_t stat;

    las_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    las_datapath #(.QUERY_MAX(QUERY_MAX)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_symbol  (s_tdata),
        .s_last    (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    // a zero best score always comes with a zero position
    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[14:0] == '0) |-> (m_tdata[41:15] == '0))
        else $error("zero score with nonzero position");

    // a subject transfer keeps the input closed while its row is scored
    a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == KIND_SUBJECT) |=> !s_tready)
        else $error("input open during row scoring");

    // a new result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out) |-> (!m_tvalid || m_tready))
        else $error("result overwritten");

endmodule
